/* sv/wma_pkg.sv */
// shared types and constants for the windowed moving average
`default_nettype none

package wma_pkg;

    // result format: signed fixed point
    localparam int AVG_BITS  = 24;
    localparam int FRAC_BITS = 8;

    // status of the serial divider as seen by its controller
    typedef struct packed {
        logic busy;
        logic done;
    } wma_div_stat_t;

endpackage

`default_nettype wire

/* sv/windowed_moving_average.sv */
// windowed moving average over a ring buffer of recent samples
`default_nettype none

// Takes one transaction at a time: a signed sample, or a restart that clears the
// running sum, fill count and full flag and answers 0. Samples are stored in a
// ring buffer RAM of WINDOW_LENGTH entries with an exact running sum alongside;
// the result is sum * 256 / n truncated toward zero (n = samples so far, or
// WINDOW_LENGTH once full), saturated to 24 bits. A sample transaction steps
// through updating the sum, loading the bit-serial divider, dividing at one
// quotient bit per cycle and registering the result; the input is ready again
// in the same cycle that the result is registered. A restart skips the sum and
// divider and goes straight to the output register. A result that is still
// waiting in the output register holds the next result back, and with it the
// input. The ring buffer needs no clearing pass after reset since an entry is
// only read once the window has filled. The output register lets a new
// transaction be accepted while the previous result waits to be taken.
module windowed_moving_average #(
    parameter int WINDOW_LENGTH = 16,
    parameter int SAMPLE_BITS   = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output      logic                                  s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]         s_sample,
    input  wire logic                                  s_restart,
    output      logic                                  m_valid,
    input  wire logic                                  m_ready,
    output      logic signed [wma_pkg::AVG_BITS-1:0]   m_average,
    output      logic                                  m_window_full
);
    import wma_pkg::*;

    localparam int CW = $clog2(WINDOW_LENGTH);
    localparam int NW = CW + 1;
    localparam int SW = SAMPLE_BITS + CW;
    localparam int QW = SAMPLE_BITS + FRAC_BITS;
    localparam int XW = (QW + 1 > AVG_BITS) ? QW + 1 : AVG_BITS;

    localparam logic signed [XW-1:0] AVG_MAX_X = XW'(2 ** (AVG_BITS - 1) - 1);
    localparam logic signed [XW-1:0] AVG_MIN_X = -(XW'(2 ** (AVG_BITS - 1)));

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUM  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic [CW-1:0]                 idx_reg, idx_next;
    logic                          full_reg, full_next;
    logic signed [SW-1:0]          sum_reg, sum_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic                          restart_reg, restart_next;
    logic                          neg_reg, neg_next;
    logic [NW-1:0]                 div_n_reg, div_n_next;
    logic                          m_valid_reg, m_valid_next;
    logic [AVG_BITS-1:0]           m_average_reg, m_average_next;
    logic                          m_window_full_reg, m_window_full_next;

    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic                          ram_we;
    logic [SW-1:0]                 sum_mag;
    logic                          div_start;
    logic [QW-1:0]                 quotient;
    wma_div_stat_t                 div_stat;
    logic signed [QW:0]            q_signed;
    logic signed [XW-1:0]          q_ext;
    logic signed [XW-1:0]          q_sat;
    logic                          in_txn;
    logic                          out_free;
    logic                          idx_last;

    wma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_LENGTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (sample_reg),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    wma_sdiv #(
        .NW (NW),
        .QW (QW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .rem_init ({1'b0, sum_mag[SW-1:SAMPLE_BITS]}),
        .quo_init ({sum_mag[SAMPLE_BITS-1:0], {FRAC_BITS{1'b0}}}),
        .divisor  (div_n_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_txn   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign idx_last = (idx_reg == CW'(WINDOW_LENGTH - 1));
    assign ram_we   = (state_reg == ST_SUM);

    // magnitude of the running sum and signed, saturated quotient
    always_comb begin
        sum_mag  = sum_reg[SW-1] ? (~sum_reg + 1'b1) : sum_reg;
        q_signed = neg_reg ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
        q_ext    = XW'(q_signed);
        if (q_ext > AVG_MAX_X) begin
            q_sat = AVG_MAX_X;
        end else if (q_ext < AVG_MIN_X) begin
            q_sat = AVG_MIN_X;
        end else begin
            q_sat = q_ext;
        end
    end

    always_comb begin
        state_next         = state_reg;
        idx_next           = idx_reg;
        full_next          = full_reg;
        sum_next           = sum_reg;
        sample_next        = sample_reg;
        restart_next       = restart_reg;
        neg_next           = neg_reg;
        div_n_next         = div_n_reg;
        m_valid_next       = m_valid_reg;
        m_average_next     = m_average_reg;
        m_window_full_next = m_window_full_reg;
        div_start          = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_txn) begin
                    sample_next  = s_sample;
                    restart_next = s_restart;
                    if (s_restart) begin
                        idx_next   = '0;
                        full_next  = 1'b0;
                        sum_next   = '0;
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                // oldest entry only counts once the window is full
                sum_next = sum_reg + SW'(sample_reg)
                         - (full_reg ? SW'($signed(ram_rdata)) : SW'(0));
                div_n_next = full_reg ? NW'(WINDOW_LENGTH) : ({1'b0, idx_reg} + 1'b1);
                if (idx_last) begin
                    idx_next  = '0;
                    full_next = 1'b1;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (!div_stat.busy) begin
                    neg_next   = sum_reg[SW-1];
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_average_next     = restart_reg ? '0 : q_sat[AVG_BITS-1:0];
                    m_window_full_next = full_reg;
                    state_next         = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            full_reg    <= 1'b0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            full_reg    <= full_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
        sample_reg        <= sample_next;
        restart_reg       <= restart_next;
        neg_reg           <= neg_next;
        div_n_reg         <= div_n_next;
        m_average_reg     <= m_average_next;
        m_window_full_reg <= m_window_full_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_average     = m_average_reg;
    assign m_window_full = m_window_full_reg;

endmodule

`default_nettype wire

/* sv/wma_ram.sv */
// generic single-port-write ram with registered read
`default_nettype none

module wma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* sv/wma_sdiv.sv */
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module wma_sdiv #(
    parameter int NW = 5,
    parameter int QW = 24
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [NW-1:0]          rem_init,
    input  wire logic [QW-1:0]          quo_init,
    input  wire logic [NW-1:0]          divisor,
    output      logic [QW-1:0]          quotient,
    output      wma_pkg::wma_div_stat_t stat
);
    import wma_pkg::*;

    localparam int CNTW = $clog2(QW);

    logic [NW+QW-1:0] rq_reg, rq_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic             busy_reg, busy_next;

    logic [NW:0]      shifted;
    logic [NW:0]      diff;
    logic             ge;
    logic [NW-1:0]    new_rem;

    // partial remainder shifts left one dividend bit per cycle
    always_comb begin
        shifted = {rq_reg[NW+QW-1:QW], rq_reg[QW-1]};
        ge      = shifted >= {1'b0, divisor};
        diff    = shifted - {1'b0, divisor};
        new_rem = ge ? diff[NW-1:0] : shifted[NW-1:0];
    end

    always_comb begin
        rq_next   = rq_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rq_next   = {rem_init, quo_init};
            cnt_next  = CNTW'(QW - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rq_next = {new_rem, rq_reg[QW-2:0], ge};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rq_reg <= rq_next;
    end

    assign quotient  = rq_reg[QW-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (cnt_reg == '0);

endmodule

`default_nettype wire

/* sv/wma_checker.sv */
// port-level checks for the windowed moving average, bound to the top level
`default_nettype none

module wma_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_valid,
    input wire logic                                s_ready,
    input wire logic signed [SAMPLE_BITS-1:0]       s_sample,
    input wire logic                                s_restart,
    input wire logic                                m_valid,
    input wire logic                                m_ready,
    input wire logic signed [wma_pkg::AVG_BITS-1:0] m_average,
    input wire logic                                m_window_full
);
    import wma_pkg::*;

    // no result straight after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_average) && $stable(m_window_full))
        else $error("stalled result changed");

    // one transaction in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

    // a new result only follows an accepted transaction
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without a transaction in flight");

    // a waiting input transaction holds its payload
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_sample) && $stable(s_restart))
        else $error("waiting input changed");

endmodule

bind windowed_moving_average wma_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_wma_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_sample      (s_sample),
    .s_restart     (s_restart),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_average     (m_average),
    .m_window_full (m_window_full)
);

`default_nettype wire
